// File: hw/rtl/still_window_offset_calibrator_top_defines.svh
// Assertion helpers; clk and rst come from the scope of use.
`ifndef STILL_WINDOW_OFFSET_CALIBRATOR_TOP_DEFINES_SVH
`define STILL_WINDOW_OFFSET_CALIBRATOR_TOP_DEFINES_SVH

// same-cycle implication
`define SWOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/swoc_pkg.sv
package swoc_pkg;

  localparam int AXES            = 3;
  localparam int SAMPLE_W        = 16;
  localparam int SPREAD_W        = 17;
  localparam int NUM_SAMPLES_DEF = 32;
  localparam int TDATA_W         = ((AXES * SAMPLE_W + 7) / 8) * 8;
  localparam int TUSER_W         = 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SPREAD_W-1:0]        spread_t;

  localparam spread_t SPREAD_RESET = spread_t'(100);

endpackage

// File: hw/rtl/still_window_offset_calibrator_top.sv
// Zero-offset calibrator for a three-axis sensor. Takes one sample per clock
// on s_axis when tready is high and gathers windows of NUM_SAMPLES samples,
// tracking per-axis min, max and sum. The last sample of a window yields one
// result on m_axis via the window register and the mean stages: ok is set
// when every axis spread (max - min) is below max_spread, and then the offsets
// are the per-axis means truncated toward zero, else zero. Sustained rate,
// unless m_axis stalls, is one sample per cycle; the mean uses a two-stage
// reciprocal multiply. Write max_spread on cfg only while the block is idle.
module still_window_offset_calibrator_top #(
  parameter int NUM_SAMPLES = swoc_pkg::NUM_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [swoc_pkg::TDATA_W-1:0]   s_axis_tdata,  // sample_x, sample_y, sample_z
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [swoc_pkg::TDATA_W-1:0]   m_axis_tdata,  // offset_x, offset_y, offset_z
  output logic [swoc_pkg::TUSER_W-1:0]   m_axis_tuser,  // ok
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swoc_pkg::SPREAD_W-1:0]  cfg_data       // max_spread
);
  import swoc_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(NUM_SAMPLES);

  spread_t                 max_spread;
  sample_t                 sample  [AXES];
  logic                    win_valid;
  logic                    win_ready;
  sample_t                 win_min [AXES];
  sample_t                 win_max [AXES];
  logic signed [SUM_W-1:0] win_sum [AXES];
  logic                    ok;
  sample_t                 offset  [AXES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_spread <= SPREAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_spread <= cfg_data;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int a = 0; a < AXES; a++) begin
      sample[a]                          = s_axis_tdata[a*SAMPLE_W +: SAMPLE_W];
      m_axis_tdata[a*SAMPLE_W +: SAMPLE_W] = offset[a];
    end
  end

  assign m_axis_tuser = TUSER_W'(ok);

  swoc_accum #(
    .NUM_SAMPLES(NUM_SAMPLES)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .sample    (sample),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_min   (win_min),
    .win_max   (win_max),
    .win_sum   (win_sum)
  );

  swoc_mean #(
    .NUM_SAMPLES(NUM_SAMPLES)
  ) u_mean (
    .clk        (clk),
    .rst        (rst),
    .max_spread (max_spread),
    .in_valid   (win_valid),
    .in_ready   (win_ready),
    .win_min    (win_min),
    .win_max    (win_max),
    .win_sum    (win_sum),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .ok         (ok),
    .offset     (offset)
  );

endmodule

// File: hw/rtl/swoc_accum.sv
module swoc_accum #(
  parameter int  NUM_SAMPLES = swoc_pkg::NUM_SAMPLES_DEF,
  localparam int SUM_W       = swoc_pkg::SAMPLE_W + $clog2(NUM_SAMPLES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  swoc_pkg::sample_t       sample  [swoc_pkg::AXES],
  output logic                    win_valid,
  input  logic                    win_ready,
  output swoc_pkg::sample_t       win_min [swoc_pkg::AXES],
  output swoc_pkg::sample_t       win_max [swoc_pkg::AXES],
  output logic signed [SUM_W-1:0] win_sum [swoc_pkg::AXES]
);
  import swoc_pkg::*;

  localparam int CNT_W = $clog2(NUM_SAMPLES);

  logic [CNT_W-1:0]        count;
  sample_t                 amin     [AXES];
  sample_t                 amax     [AXES];
  logic signed [SUM_W-1:0] asum     [AXES];
  sample_t                 min_next [AXES];
  sample_t                 max_next [AXES];
  logic signed [SUM_W-1:0] sum_next [AXES];
  logic                    first;
  logic                    last;
  logic                    take;

  assign in_ready = !win_valid || win_ready;
  assign take     = in_valid && in_ready;
  assign first    = (count == '0);
  assign last     = (count == CNT_W'(NUM_SAMPLES - 1));

  // first sample of a window reloads min/max and restarts the sum
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      min_next[a] = (first || sample[a] < amin[a]) ? sample[a] : amin[a];
      max_next[a] = (first || sample[a] > amax[a]) ? sample[a] : amax[a];
      sum_next[a] = (first ? SUM_W'(0) : asum[a]) + SUM_W'(sample[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      win_valid <= 1'b0;
    end else begin
      if (win_ready) begin
        win_valid <= 1'b0;
      end
      if (take) begin
        if (last) begin
          count     <= '0;
          win_valid <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      amin <= min_next;
      amax <= max_next;
      asum <= sum_next;
      if (last) begin
        win_min <= min_next;
        win_max <= max_next;
        win_sum <= sum_next;
      end
    end
  end

endmodule

// File: hw/rtl/swoc_mean.sv
module swoc_mean #(
  parameter int  NUM_SAMPLES = swoc_pkg::NUM_SAMPLES_DEF,
  localparam int SUM_W       = swoc_pkg::SAMPLE_W + $clog2(NUM_SAMPLES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swoc_pkg::spread_t       max_spread,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  swoc_pkg::sample_t       win_min [swoc_pkg::AXES],
  input  swoc_pkg::sample_t       win_max [swoc_pkg::AXES],
  input  logic signed [SUM_W-1:0] win_sum [swoc_pkg::AXES],
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    ok,
  output swoc_pkg::sample_t       offset  [swoc_pkg::AXES]
);
  import swoc_pkg::*;

  // divide by NUM_SAMPLES as multiply by ceil(2^K / N), exact for |sum| < 2^SUM_W
  localparam int          LOG_N    = $clog2(NUM_SAMPLES);
  localparam int          K        = SUM_W + LOG_N;
  localparam int          RW       = SUM_W + 1;
  localparam int          LO_W     = RW / 2;
  localparam int          HI_W     = RW - LO_W;
  localparam int          PLO_W    = SUM_W + LO_W;
  localparam int          PHI_W    = SUM_W + HI_W;
  localparam int          PW       = SUM_W + RW;
  localparam logic [63:0] RECIP    = ((64'd1 << K) + 64'(NUM_SAMPLES) - 64'd1)
                                     / 64'(NUM_SAMPLES);
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[LO_W +: HI_W];

  logic             adv1;
  logic             adv2;
  logic             still;
  spread_t          spread [AXES];
  logic [SUM_W-1:0] mag    [AXES];
  logic [PW-1:0]    full   [AXES];
  logic [SAMPLE_W-1:0] quot [AXES];
  sample_t          off_next [AXES];

  logic             v1;
  logic             ok1;
  logic             neg1   [AXES];
  logic [PLO_W-1:0] p_lo   [AXES];
  logic [PHI_W-1:0] p_hi   [AXES];
  logic             v2;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v2;

  always_comb begin
    still = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      spread[a] = SPREAD_W'(win_max[a]) - SPREAD_W'(win_min[a]);
      if (!(spread[a] < max_spread)) begin
        still = 1'b0;
      end
      mag[a] = win_sum[a][SUM_W-1] ? SUM_W'(-win_sum[a]) : SUM_W'(win_sum[a]);
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      full[a]     = (PW'(p_hi[a]) << LO_W) + PW'(p_lo[a]);
      quot[a]     = full[a][K +: SAMPLE_W];
      off_next[a] = !ok1   ? sample_t'(0) :
                    neg1[a] ? sample_t'(-quot[a]) : sample_t'(quot[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      ok1 <= still;
      for (int a = 0; a < AXES; a++) begin
        neg1[a] <= win_sum[a][SUM_W-1];
        p_lo[a] <= PLO_W'(mag[a]) * PLO_W'(RECIP_LO);
        p_hi[a] <= PHI_W'(mag[a]) * PHI_W'(RECIP_HI);
      end
    end
    if (adv2 && v1) begin
      ok     <= ok1;
      offset <= off_next;
    end
  end

endmodule

// File: hw/rtl/swoc_checker.sv
`include "still_window_offset_calibrator_top_defines.svh"

module swoc_checker #(
  parameter int NUM_SAMPLES = swoc_pkg::NUM_SAMPLES_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [swoc_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic [swoc_pkg::TUSER_W-1:0]  m_axis_tuser
);
  import swoc_pkg::*;

  localparam int CNT_W = $clog2(NUM_SAMPLES);

  logic [CNT_W-1:0] count;
  logic [2:0]       pending;
  logic             in_req;
  logic             out_req;
  logic             close;

  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign out_req = m_axis_tvalid && m_axis_tready;
  assign close   = in_req && (count == CNT_W'(NUM_SAMPLES - 1));

  // closed windows not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pending <= '0;
    end else begin
      if (in_req) begin
        count <= close ? '0 : count + 1'b1;
      end
      pending <= pending + 3'(close) - 3'(out_req);
    end
  end

  `SWOC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `SWOC_ASSERT_NOW(a_fail_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "nonzero offsets on failed window")
  `SWOC_ASSERT_NOW(a_no_phantom, m_axis_tvalid, pending != 3'd0, "result without a closed window")
  `SWOC_ASSERT_NOW(a_pend_bound, 1'b1, pending <= 3'd3, "too many windows in flight")

endmodule

bind still_window_offset_calibrator_top swoc_checker #(
  .NUM_SAMPLES(NUM_SAMPLES)
) u_swoc_checker (.*);

// File: tb/tb_still_window_offset_calibrator_top.sv
`timescale 1ns / 1ps

module tb_still_window_offset_calibrator_top;
  import swoc_pkg::*;

  localparam int WINDOW     = NUM_SAMPLES_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int MAX_WAIT   = 8;

  typedef struct packed {
    logic                         ok;
    logic [AXES-1:0][SAMPLE_W-1:0] ofs;
  } calib_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic [TUSER_W-1:0]   m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  spread_t              cfg_data = '0;

  logic [TDATA_W-1:0]   sample_q[$];
  calib_t               calib_q[$];

  // calibrator state as predicted
  spread_t              spread_limit = SPREAD_RESET;
  int                   fill_count = 0;
  sample_t              axis_lo[AXES];
  sample_t              axis_hi[AXES];
  logic signed [20:0]   axis_sum[AXES] = '{default: '0};

  int  errors = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;
  int  in_wait = 0;
  bit  in_calm = 1'b0;
  int  out_wait = -1;
  bit  out_calm = 1'b0;

  still_window_offset_calibrator_top #(.NUM_SAMPLES(WINDOW)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic take_sample(logic [TDATA_W-1:0] word);
    sample_t s;
    spread_t diff;
    calib_t  res;
    res.ok = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      s = word[a*SAMPLE_W +: SAMPLE_W];
      if (fill_count == 0) begin
        axis_lo[a] = s;
        axis_hi[a] = s;
        axis_sum[a] = '0;
      end else begin
        if (s < axis_lo[a]) axis_lo[a] = s;
        if (s > axis_hi[a]) axis_hi[a] = s;
      end
      axis_sum[a] += s;
    end
    fill_count++;
    if (fill_count == WINDOW) begin
      for (int a = 0; a < AXES; a++) begin
        diff = spread_t'(int'(axis_hi[a]) - int'(axis_lo[a]));
        if (!(diff < spread_limit)) res.ok = 1'b0;
      end
      for (int a = 0; a < AXES; a++)
        res.ofs[a] = res.ok ? sample_t'(axis_sum[a] / WINDOW) : '0;
      calib_q.push_back(res);
      fill_count = 0;
    end
  endtask

  task automatic check_result(logic [TDATA_W-1:0] word, logic ok_bit);
    calib_t want;
    if (calib_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result ok=%0b offsets=%h", $time, ok_bit, word);
    end else begin
      want = calib_q.pop_front();
      if (ok_bit !== want.ok) begin
        errors++;
        $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok_bit);
      end
      for (int a = 0; a < AXES; a++)
        if (word[a*SAMPLE_W +: SAMPLE_W] !== want.ofs[a]) begin
          errors++;
          $display("%0t: offset axis %0d expected %0d actual %0d", $time, a,
                   $signed(want.ofs[a]), $signed(word[a*SAMPLE_W +: SAMPLE_W]));
        end
    end
  endtask

  always @(posedge clk) begin
    in_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (in_taken) take_sample(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata, m_axis_tuser[0]);
      out_wait = -1;
    end
    if (!rst && cfg_valid && cfg_ready) spread_limit = cfg_data;
  end

  // sample driver
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (in_wait > 0) begin
        in_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        s_axis_tdata  <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        in_wait = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_wait < 0 && m_axis_tvalid) out_wait = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (out_wait > 0) begin
        out_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (out_wait == 0) || out_calm;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_still_window_offset_calibrator_top failed");
      $finish;
    end
  end

  function automatic void push_sample(int x, int y, int z);
    sample_q.push_back({sample_t'(z), sample_t'(y), sample_t'(x)});
  endfunction

  // window whose per-axis spread is zero, below, on or near the current limit, or random
  task automatic queue_random_window();
    sample_t win[WINDOW][AXES];
    int      span;
    int      lo;
    int      lo_idx;
    int      hi_idx;
    bit      pass_bias;
    pass_bias = $urandom_range(0, 1);
    for (int a = 0; a < AXES; a++) begin
      case ($urandom_range(0, pass_bias ? 2 : 5))
        0: span = 0;
        1: span = int'(spread_limit) - 1;
        2: span = (spread_limit > 1) ? $urandom_range(0, spread_limit - 1) : 0;
        3: span = spread_limit;
        4: span = int'(spread_limit) + 1;
        default: span = $urandom_range(0, 65535);
      endcase
      if (span < 0) span = 0;
      if (span > 65535) span = 65535;
      lo = int'($urandom_range(0, 65535 - span)) - 32768;
      for (int i = 0; i < WINDOW; i++) win[i][a] = sample_t'(lo + int'($urandom_range(0, span)));
      lo_idx = $urandom_range(0, WINDOW - 1);
      hi_idx = (lo_idx + 1 + $urandom_range(0, WINDOW - 2)) % WINDOW;
      win[lo_idx][a] = sample_t'(lo);
      win[hi_idx][a] = sample_t'(lo + span);
    end
    for (int i = 0; i < WINDOW; i++) sample_q.push_back({win[i][2], win[i][1], win[i][0]});
  endtask

  task automatic write_spread(spread_t value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || s_axis_tvalid || calib_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    spread_t limits[10];
    limits = '{spread_t'(0), spread_t'(1), spread_t'(2), spread_t'(65536),
               spread_t'(131071), spread_t'(100), spread_t'(65535), spread_t'(40000),
               spread_t'($urandom_range(3, 5000)), spread_t'($urandom_range(3, 300))};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limit of 100: extremes, truncation toward zero, limit boundary
    for (int i = 0; i < WINDOW; i++) push_sample(32767, -32768, 0);
    for (int i = 0; i < WINDOW; i++)
      if (i < WINDOW / 2) push_sample(-3, 3, 1);
      else push_sample(0, 0, -2);
    for (int i = 0; i < WINDOW; i++)
      if (i % 2) push_sample(32767, -32768, 32767);
      else push_sample(-32768, 32767, -32768);
    for (int i = 0; i < WINDOW; i++) push_sample((i == 5) ? 99 : 0, (i % 3) ? -50 : 49, 7);
    for (int i = 0; i < WINDOW; i++) push_sample(-7, (i == 9) ? 50 : -50, 7);
    wait_drained();
    repeat (4) queue_random_window();
    wait_drained();

    foreach (limits[p]) begin
      write_spread(limits[p]);
      repeat (5) queue_random_window();
      wait_drained();
    end

    if (errors == 0)
      $display("tb_still_window_offset_calibrator_top passed");
    else
      $display("tb_still_window_offset_calibrator_top failed");
    $finish;
  end

endmodule
